/* hw/rtl/jbt_pkg.sv */
// Shared types, constants and the literal-word table of the JSON byte tokenizer.
// Depends on nothing; every other file of the block imports it.
package jbt_pkg;

   // Longest token, in content bytes, before an error is flagged.
   localparam int MAX_TOKEN_LEN = 1023;
   localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 1);
   localparam int TLEN_W        = 10;

   // Queue depths; both must be powers of two so the pointers wrap naturally.
   localparam int INQ_DEPTH  = 2;
   localparam int INQ_AW     = $clog2(INQ_DEPTH);
   localparam int INQ_CW     = INQ_AW + 1;
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = OUTQ_AW + 1;

   // Characters with a special meaning.
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // Token type codes.
   localparam logic [3:0] TT_BOOL   = 4'd0;
   localparam logic [3:0] TT_RBRACK = 4'd1;
   localparam logic [3:0] TT_RBRACE = 4'd2;
   localparam logic [3:0] TT_COLON  = 4'd3;
   localparam logic [3:0] TT_COMMA  = 4'd4;
   localparam logic [3:0] TT_NULL   = 4'd5;
   localparam logic [3:0] TT_NUMBER = 4'd6;
   localparam logic [3:0] TT_LBRACK = 4'd7;
   localparam logic [3:0] TT_LBRACE = 4'd8;
   localparam logic [3:0] TT_STRING = 4'd9;
   localparam logic [3:0] TT_NONE   = 4'd0;

   // Error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_UNCLOSED = 2'd1;
   localparam logic [1:0] ERR_UNEXP    = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG = 2'd3;

   // Literal words.
   localparam logic [1:0] LIT_FALSE = 2'd0;
   localparam logic [1:0] LIT_TRUE  = 2'd1;
   localparam logic [1:0] LIT_NULL  = 2'd2;

   typedef enum logic [1:0] {
      KIND_CONTENT = 2'd0,
      KIND_TOKEN   = 2'd1,
      KIND_ERROR   = 2'd2,
      KIND_END     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_STRING    = 3'd1,
      MODE_NUM_INT   = 3'd2,
      MODE_NUM_FRAC  = 3'd3,
      MODE_EXP_START = 3'd4,
      MODE_EXP       = 3'd5,
      MODE_LITERAL   = 3'd6
   } mode_type;

   // A byte as the front end classifies it.
   typedef struct packed {
      logic [7:0] c;
      logic       is_end;
      logic       is_digit;
      logic       is_space;
      logic       is_sign;
      logic       is_quote;
      logic       is_dot;
      logic       is_exp;
      logic       is_lit;
      logic [1:0] lit_kind;
      logic       is_punct;
      logic [3:0] punct_tt;
   } byte_class_type;

   // One result item.
   typedef struct packed {
      kind_type          kind;
      logic [3:0]        ttype;
      logic [7:0]        cbyte;
      logic [TLEN_W-1:0] tlen;
      logic              bval;
      logic [1:0]        ecode;
      logic              last;
   } result_type;

   // Results that the lexer hands to the result queue in one cycle.
   typedef struct packed {
      logic [1:0] n;
      result_type r0;
      result_type r1;
   } rsp_push_type;

   // Expected letter at a position of a literal word.
   function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
      logic [2:0] p;
      logic [7:0] ch;
      p = (pos > 3'd4) ? 3'd4 : pos;
      ch = CH_NUL;
      unique case (kind)
         LIT_FALSE: begin
            unique case (p)
               3'd0:    ch = "f";
               3'd1:    ch = "a";
               3'd2:    ch = "l";
               3'd3:    ch = "s";
               default: ch = "e";
            endcase
         end
         LIT_TRUE: begin
            unique case (p)
               3'd0:    ch = "t";
               3'd1:    ch = "r";
               3'd2:    ch = "u";
               3'd3:    ch = "e";
               default: ch = CH_NUL;
            endcase
         end
         default: begin
            unique case (p)
               3'd0:    ch = "n";
               3'd1:    ch = "u";
               3'd2:    ch = "l";
               3'd3:    ch = "l";
               default: ch = CH_NUL;
            endcase
         end
      endcase
      return ch;
   endfunction

   // Number of letters in a literal word.
   function automatic logic [2:0] lit_len(input logic [1:0] kind);
      return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
   endfunction

endpackage

/* hw/rtl/json_byte_tokenizer_unit.sv */
// Top level of the JSON byte tokenizer: input classifier, lexer and result queue.
// Depends on jbt_pkg, jbt_front, jbt_back and jbt_outq.
//
// The tokenizer takes one byte of JSON text per transfer on the request side
// (push/full) and returns content-byte, token, error and end-of-document
// results on the response side (empty/pop), oldest first. It accepts one byte
// every clock cycle as long as results are taken at the same pace; the lexer
// state machine in the back end handles one byte per cycle, and the result
// queue drains one result per cycle. A byte is written into a two-entry queue
// at its transfer edge; the lexer takes it from the head of that queue as
// soon as the result queue has room, and the results the lexer makes of it
// are registered in the result queue, whose oldest entry drives the response
// ports. A byte that ends a number and also starts another
// token gives two results; the four-entry result queue absorbs them, so only
// a long run of such bytes with no idle cycles slows the request side down.
// The lexer stalls whenever the result queue has fewer than two free entries,
// and full rises once the input queue holds two bytes. A zero byte or a byte
// with req_end_of_input set closes the document: any number in progress is
// finished, an open string or literal is flagged, an end-of-document result
// follows, and the lexer returns to its reset state. After an error, bytes are
// dropped silently until the end of the document. The last result caused by
// one input byte carries rsp_last_result.
module json_byte_tokenizer_unit
   import jbt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [3:0]  rsp_token_code,
   output logic [7:0]  rsp_content_byte,
   output logic [9:0]  rsp_token_length,
   output logic        rsp_bool_value,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_result
);

   logic           q_valid;
   byte_class_type q_head;
   logic           q_pop;
   logic           out_room;
   rsp_push_type   rsp_push;
   result_type     head;

   jbt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .full             (full),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop)
   );

   jbt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .out_room (out_room),
      .rsp_push (rsp_push)
   );

   jbt_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .out_room (out_room),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   // The oldest waiting result drives the response fields.
   assign rsp_result_kind  = head.kind;
   assign rsp_token_code   = head.ttype;
   assign rsp_content_byte = head.cbyte;
   assign rsp_token_length = head.tlen;
   assign rsp_bool_value   = head.bval;
   assign rsp_error_code   = head.ecode;
   assign rsp_last_result  = head.last;

endmodule

/* hw/rtl/jbt_front.sv */
// Front end of the JSON byte tokenizer: classifies each byte and holds it in a
// two-entry queue until the lexer takes it. Depends on jbt_pkg.
module jbt_front
   import jbt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  logic [7:0]     req_data_byte,
   input  logic           req_end_of_input,
   output logic           full,
   output logic           q_valid,
   output byte_class_type q_head,
   input  logic           q_pop
);

   byte_class_type            cls;
   byte_class_type            mem [INQ_DEPTH];
   logic [INQ_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [INQ_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [INQ_CW-1:0]         count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   always_comb begin
      cls          = '0;
      cls.c        = req_data_byte;
      cls.is_end   = req_end_of_input || (req_data_byte == CH_NUL);
      cls.is_digit = (req_data_byte >= CH_ZERO) && (req_data_byte <= CH_NINE);
      cls.is_space = (req_data_byte == CH_SPACE) ||
                     ((req_data_byte >= CH_TAB) && (req_data_byte <= CH_CR));
      cls.is_sign  = (req_data_byte == CH_PLUS) || (req_data_byte == CH_MINUS);
      cls.is_quote = (req_data_byte == CH_QUOTE);
      cls.is_dot   = (req_data_byte == CH_DOT);
      cls.is_exp   = (req_data_byte == CH_LOW_E);
      cls.is_lit   = (req_data_byte == CH_LOW_F) || (req_data_byte == CH_LOW_T) ||
                     (req_data_byte == CH_LOW_N);
      cls.lit_kind = (req_data_byte == CH_LOW_F) ? LIT_FALSE :
                     ((req_data_byte == CH_LOW_T) ? LIT_TRUE : LIT_NULL);
      cls.is_punct = 1'b1;
      priority case (req_data_byte)
         CH_RBRACK: cls.punct_tt = TT_RBRACK;
         CH_RBRACE: cls.punct_tt = TT_RBRACE;
         CH_COLON:  cls.punct_tt = TT_COLON;
         CH_COMMA:  cls.punct_tt = TT_COMMA;
         CH_LBRACK: cls.punct_tt = TT_LBRACK;
         CH_LBRACE: cls.punct_tt = TT_LBRACE;
         default: begin
            cls.is_punct = 1'b0;
            cls.punct_tt = TT_NONE;
         end
      endcase
   end

   assign full    = (count_ff == INQ_CW'(INQ_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_head  = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + INQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + INQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + INQ_CW'(do_push) - INQ_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* hw/rtl/jbt_back.sv */
// Back end of the JSON byte tokenizer: while the result queue has room, the lexer state
// machine turns one classified byte a cycle into zero, one or two results. Depends on jbt_pkg.
module jbt_back
   import jbt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  byte_class_type q_head,
   output logic           q_pop,
   input  logic           out_room,
   output rsp_push_type   rsp_push
);

   mode_type         mode_ff, mode_in;
   logic [1:0]       lkind_ff, lkind_in;
   logic [2:0]       lpos_ff, lpos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             err_ff, err_in;
   logic             fire;

   // Outcome of taking the current byte as the start of a new token.
   logic             st_emit;
   result_type       st_res;
   mode_type         st_mode;
   logic [CNT_W-1:0] st_count;
   logic [1:0]       st_lkind;
   logic [2:0]       st_lpos;
   logic             st_err;

   logic             do_app;
   logic [3:0]       app_tt;
   logic             do_finish;
   logic [2:0]       p_cl;
   logic [2:0]       p_next;
   result_type       r0, r1;
   logic [1:0]       n;

   function automatic result_type mk_res(input kind_type kind, input logic [3:0] tt,
                                         input logic [7:0] b, input logic [TLEN_W-1:0] len,
                                         input logic bv, input logic [1:0] ec);
      result_type r;
      r.kind  = kind;
      r.ttype = tt;
      r.cbyte = b;
      r.tlen  = len;
      r.bval  = bv;
      r.ecode = ec;
      r.last  = 1'b0;
      return r;
   endfunction

   assign fire  = q_valid && out_room;
   assign q_pop = fire;

   always_comb begin
      st_emit  = 1'b0;
      st_res   = '0;
      st_mode  = MODE_IDLE;
      st_count = '0;
      st_lkind = lkind_ff;
      st_lpos  = lpos_ff;
      st_err   = 1'b0;
      priority if (q_head.is_space) begin
         st_emit = 1'b0;
      end else if (q_head.is_quote) begin
         st_mode = MODE_STRING;
      end else if (q_head.is_digit || q_head.is_sign) begin
         st_mode  = MODE_NUM_INT;
         st_count = CNT_W'(1);
         st_emit  = 1'b1;
         st_res   = mk_res(KIND_CONTENT, TT_NUMBER, q_head.c, '0, 1'b0, ERR_NONE);
      end else if (q_head.is_lit) begin
         st_mode  = MODE_LITERAL;
         st_lkind = q_head.lit_kind;
         st_lpos  = 3'd1;
      end else if (q_head.is_punct) begin
         st_emit = 1'b1;
         st_res  = mk_res(KIND_TOKEN, q_head.punct_tt, 8'd0, '0, 1'b0, ERR_NONE);
      end else begin
         st_emit = 1'b1;
         st_err  = 1'b1;
         st_res  = mk_res(KIND_ERROR, TT_NONE, 8'd0, '0, 1'b0, ERR_UNEXP);
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      lkind_in  = lkind_ff;
      lpos_in   = lpos_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      r0        = '0;
      r1        = '0;
      n         = 2'd0;
      do_app    = 1'b0;
      app_tt    = TT_NUMBER;
      do_finish = 1'b0;
      p_cl      = (lpos_ff > 3'd4) ? 3'd4 : lpos_ff;
      p_next    = p_cl + 3'd1;

      if (q_head.is_end) begin
         if (!err_ff) begin
            unique case (mode_ff)
               MODE_STRING: begin
                  r0 = mk_res(KIND_ERROR, TT_NONE, 8'd0, '0, 1'b0, ERR_UNCLOSED);
                  n  = 2'd1;
               end
               MODE_NUM_INT, MODE_NUM_FRAC, MODE_EXP_START, MODE_EXP: begin
                  r0 = mk_res(KIND_TOKEN, TT_NUMBER, 8'd0, TLEN_W'(count_ff), 1'b0,
                              ERR_NONE);
                  n  = 2'd1;
               end
               MODE_LITERAL: begin
                  r0 = mk_res(KIND_ERROR, TT_NONE, 8'd0, '0, 1'b0, ERR_UNEXP);
                  n  = 2'd1;
               end
               default: begin
                  n = 2'd0;
               end
            endcase
         end
         if (n == 2'd0) begin
            r0 = mk_res(KIND_END, TT_NONE, 8'd0, '0, 1'b0, ERR_NONE);
         end else begin
            r1 = mk_res(KIND_END, TT_NONE, 8'd0, '0, 1'b0, ERR_NONE);
         end
         n        = n + 2'd1;
         mode_in  = MODE_IDLE;
         lkind_in = '0;
         lpos_in  = '0;
         count_in = '0;
         err_in   = 1'b0;
      end else if (!err_ff) begin
         unique case (mode_ff)
            MODE_STRING: begin
               if (q_head.is_quote) begin
                  r0       = mk_res(KIND_TOKEN, TT_STRING, 8'd0, TLEN_W'(count_ff), 1'b0,
                                    ERR_NONE);
                  n        = 2'd1;
                  mode_in  = MODE_IDLE;
                  count_in = '0;
               end else begin
                  do_app = 1'b1;
                  app_tt = TT_STRING;
               end
            end
            MODE_NUM_INT: begin
               priority if (q_head.is_digit) begin
                  do_app = 1'b1;
               end else if (q_head.is_dot) begin
                  mode_in = MODE_NUM_FRAC;
                  do_app  = 1'b1;
               end else if (q_head.is_exp) begin
                  mode_in = MODE_EXP_START;
                  do_app  = 1'b1;
               end else begin
                  do_finish = 1'b1;
               end
            end
            MODE_NUM_FRAC: begin
               priority if (q_head.is_digit) begin
                  do_app = 1'b1;
               end else if (q_head.is_exp) begin
                  mode_in = MODE_EXP_START;
                  do_app  = 1'b1;
               end else begin
                  do_finish = 1'b1;
               end
            end
            MODE_EXP_START: begin
               if (q_head.is_digit || q_head.is_sign) begin
                  mode_in = MODE_EXP;
                  do_app  = 1'b1;
               end else begin
                  do_finish = 1'b1;
               end
            end
            MODE_EXP: begin
               if (q_head.is_digit) begin
                  do_app = 1'b1;
               end else begin
                  do_finish = 1'b1;
               end
            end
            MODE_LITERAL: begin
               if (q_head.c != lit_char(lkind_ff, lpos_ff)) begin
                  r0      = mk_res(KIND_ERROR, TT_NONE, 8'd0, '0, 1'b0, ERR_UNEXP);
                  n       = 2'd1;
                  err_in  = 1'b1;
                  mode_in = MODE_IDLE;
               end else if (p_next >= lit_len(lkind_ff)) begin
                  if (lkind_ff >= LIT_NULL) begin
                     r0 = mk_res(KIND_TOKEN, TT_NULL, 8'd0, '0, 1'b0, ERR_NONE);
                  end else begin
                     r0 = mk_res(KIND_TOKEN, TT_BOOL, 8'd0, '0, (lkind_ff == LIT_TRUE),
                                 ERR_NONE);
                  end
                  n        = 2'd1;
                  mode_in  = MODE_IDLE;
                  lpos_in  = '0;
                  lkind_in = '0;
               end else begin
                  lpos_in = p_next;
               end
            end
            default: begin
               // Between tokens: the byte may open a new one.
               r0       = st_res;
               n        = {1'b0, st_emit};
               mode_in  = st_mode;
               count_in = (st_mode == MODE_IDLE) ? count_ff : st_count;
               lkind_in = st_lkind;
               lpos_in  = st_lpos;
               err_in   = st_err;
            end
         endcase

         if (do_app) begin
            if (count_ff >= CNT_W'(MAX_TOKEN_LEN)) begin
               r0      = mk_res(KIND_ERROR, TT_NONE, 8'd0, '0, 1'b0, ERR_TOO_LONG);
               err_in  = 1'b1;
               mode_in = MODE_IDLE;
            end else begin
               r0       = mk_res(KIND_CONTENT, app_tt, q_head.c, '0, 1'b0, ERR_NONE);
               count_in = count_ff + CNT_W'(1);
            end
            n = 2'd1;
         end

         if (do_finish) begin
            // The byte that ends a number is the start of the next token.
            r0       = mk_res(KIND_TOKEN, TT_NUMBER, 8'd0, TLEN_W'(count_ff), 1'b0,
                              ERR_NONE);
            r1       = st_res;
            n        = st_emit ? 2'd2 : 2'd1;
            mode_in  = st_mode;
            count_in = st_count;
            lkind_in = st_lkind;
            lpos_in  = st_lpos;
            err_in   = st_err;
         end
      end

      if (n == 2'd1) begin
         r0.last = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last = 1'b1;
      end

      rsp_push.n  = fire ? n : 2'd0;
      rsp_push.r0 = r0;
      rsp_push.r1 = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         lkind_ff <= '0;
         lpos_ff  <= '0;
         count_ff <= '0;
         err_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         lkind_ff <= lkind_in;
         lpos_ff  <= lpos_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && q_head.is_end |=> mode_ff == MODE_IDLE && !err_ff && count_ff == '0)
      else $error("end of document did not return the lexer to its reset state");

   a_err_silent: assert property (@(posedge clock) disable iff (reset)
      fire && err_ff && !q_head.is_end |-> rsp_push.n == 2'd0)
      else $error("a byte after an error produced a result");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TOKEN_LEN))
      else $error("token byte count passed the length limit");
`endif

endmodule

/* hw/rtl/jbt_outq.sv */
// Result queue of the JSON byte tokenizer: takes up to two results a cycle from
// the lexer and presents the oldest one on the result ports. Depends on jbt_pkg.
module jbt_outq
   import jbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type rsp_push,
   output logic         out_room,
   input  logic         pop,
   output logic         empty,
   output result_type   head
);

   result_type         mem [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CW-1:0] count_ff, count_in;
   logic               do_pop;
   logic [OUTQ_AW-1:0] wr_ptr_next;

   assign empty       = (count_ff == '0);
   assign head        = mem[rd_ptr_ff];
   assign do_pop      = pop && !empty;
   assign out_room    = (count_ff <= OUTQ_CW'(OUTQ_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + OUTQ_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUTQ_AW'(rsp_push.n);
      rd_ptr_in = do_pop ? rd_ptr_ff + OUTQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + OUTQ_CW'(rsp_push.n) - OUTQ_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push.n != 2'd0) begin
         mem[wr_ptr_ff] <= rsp_push.r0;
      end
      if (rsp_push.n == 2'd2) begin
         mem[wr_ptr_next] <= rsp_push.r1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push.n != 2'd0 |-> count_ff <= OUTQ_CW'(OUTQ_DEPTH - 2))
      else $error("results written into a result queue without room");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= OUTQ_CW'(OUTQ_DEPTH))
      else $error("result queue count out of range");
`endif

endmodule
